[rtl/assert_macros.svh]
// Assertion macros for the RTL of the Euler rotation matrix block.
// Users supply clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ezr_pkg.sv]
// Package for the Euler ZYX rotation matrix block: widths, series constants,
// shared types and rounding functions. Depends on nothing.
package ezr_pkg;

  localparam int DW       = 16;  // angle and matrix entry width
  localparam int TW       = 32;  // signed Q2.30 trig value width
  localparam int NSTEP    = 5;   // Horner steps per series
  localparam int LANE_LAT = 2 * NSTEP + 5;
  localparam int MERGE_LAT = 5;
  localparam int LAT      = LANE_LAT + MERGE_LAT;
  localparam int OSH      = 61 - DW;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;

  // Series divisors and the reciprocal shift used for each of them.
  localparam int SIN_DIV [NSTEP] = '{110, 72, 42, 20, 6};
  localparam int SIN_SH  [NSTEP] = '{37, 37, 36, 35, 33};
  localparam int COS_DIV [NSTEP] = '{90, 56, 30, 12, 2};
  localparam int COS_SH  [NSTEP] = '{37, 36, 35, 34, 31};

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    quad_t quad;
    logic  swap;
  } fold_t;

  typedef struct packed {
    logic signed [TW-1:0] s;
    logic signed [TW-1:0] c;
  } trig_t;

  typedef struct packed {
    logic signed [DW-1:0] r00;
    logic signed [DW-1:0] r01;
    logic signed [DW-1:0] r02;
    logic signed [DW-1:0] r10;
    logic signed [DW-1:0] r11;
    logic signed [DW-1:0] r12;
    logic signed [DW-1:0] r20;
    logic signed [DW-1:0] r21;
    logic signed [DW-1:0] r22;
  } mat_t;

  // Q60 product to Q30, rounding half away from zero.
  function automatic logic signed [TW-1:0] rnd_q30(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] q;
    logic signed [TW-1:0] qq;
    m  = v[63] ? 64'(-v) : 64'(v);
    q  = (m + (64'd1 << 29)) >> 30;
    qq = q[TW-1:0];
    return v[63] ? -qq : qq;
  endfunction

  // Q60 value to a saturated Q1.(DW-1) code, rounding half away from zero.
  function automatic logic [DW-1:0] out_code(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] nq;
    logic [63:0] maxp;
    m    = v[63] ? 64'(-v) : 64'(v);
    q    = (m + (64'd1 << (OSH - 1))) >> OSH;
    nq   = 64'd0 - q;
    maxp = (64'd1 << (DW - 1)) - 64'd1;
    if (!v[63]) begin
      return (q > maxp) ? {1'b0, {(DW-1){1'b1}}} : q[DW-1:0];
    end else begin
      return (q > maxp + 64'd1) ? {1'b1, {(DW-1){1'b0}}} : nq[DW-1:0];
    end
  endfunction

endpackage

[rtl/ezr_if.sv]
// Valid/ready channel interfaces for angle triples and matrix results.
// Depends on ezr_pkg.
interface ezr_in_if import ezr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] angle_x;
  logic signed [DW-1:0] angle_y;
  logic signed [DW-1:0] angle_z;

  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface ezr_out_if import ezr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] r00;
  logic signed [DW-1:0] r01;
  logic signed [DW-1:0] r02;
  logic signed [DW-1:0] r10;
  logic signed [DW-1:0] r11;
  logic signed [DW-1:0] r12;
  logic signed [DW-1:0] r20;
  logic signed [DW-1:0] r21;
  logic signed [DW-1:0] r22;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  output ready);
endinterface

[rtl/euler_zyx_rotation_matrix.sv]
// Pipeline: the sine/cosine lanes (Horner series, two stages per term), then the merge.
// Throughput: one angle triple per cycle; the whole pipeline halts together while
// a finished matrix waits at the output register.
// Reset: rst_n (synchronous, active low) clears the item valid bits only.
`include "assert_macros.svh"

module euler_zyx_rotation_matrix import ezr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ezr_in_if.sink    in_ch,
  ezr_out_if.source out_ch
);

  // One valid bit per pipeline stage. The last bit marks the output register.
  // The datapath has no reset; only these bits say which stages hold an item.
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;
  logic           en;

  // Everything moves when the output register is empty or being drained, so
  // a new item enters on every cycle that the consumer keeps up.
  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    vld_nxt = vld_r;
    if (en) begin
      vld_nxt = {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Three identical lanes, one per axis, turn angles into sine and cosine.
  trig_t tx;
  trig_t ty;
  trig_t tz;

  ezr_sincos_lane u_lane_x (
    .clk   (clk),
    .en    (en),
    .angle (in_ch.angle_x),
    .trig  (tx)
  );

  ezr_sincos_lane u_lane_y (
    .clk   (clk),
    .en    (en),
    .angle (in_ch.angle_y),
    .trig  (ty)
  );

  ezr_sincos_lane u_lane_z (
    .clk   (clk),
    .en    (en),
    .angle (in_ch.angle_z),
    .trig  (tz)
  );

  // The merge forms the products and sums of Rz*Ry*Rx and rounds each entry.
  mat_t mat;

  ezr_merge u_merge (
    .clk (clk),
    .en  (en),
    .tx  (tx),
    .ty  (ty),
    .tz  (tz),
    .mat (mat)
  );

  assign out_ch.valid = vld_r[LAT-1];
  assign out_ch.r00   = mat.r00;
  assign out_ch.r01   = mat.r01;
  assign out_ch.r02   = mat.r02;
  assign out_ch.r10   = mat.r10;
  assign out_ch.r11   = mat.r11;
  assign out_ch.r12   = mat.r12;
  assign out_ch.r20   = mat.r20;
  assign out_ch.r21   = mat.r21;
  assign out_ch.r22   = mat.r22;

  // A stalled result must freeze every stage, or items would be lost inside.
  `ASSERT_NEXT(a_stall_freezes, out_ch.valid && !out_ch.ready, $stable(vld_r),
               "pipeline moved while the result item was stalled")
  // An accepted item must occupy the first stage on the next cycle.
  `ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, vld_r[0],
               "accepted item did not enter the pipeline")
  // With the output register empty, the block must take input.
  `ASSERT_NOW(a_ready_when_empty, !out_ch.valid, in_ch.ready,
              "input stalled with the output register empty")

endmodule

[rtl/ezr_sincos_lane.sv]
// One sine/cosine lane: octant fold, Taylor series in Horner form, quadrant map.
// Depends on ezr_pkg.
module ezr_sincos_lane import ezr_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] angle,
  output trig_t                trig
);

  // Fold stage
  logic [31:0] phase;
  logic [29:0] r;
  logic        fold;
  logic [29:0] arg_r;
  fold_t       fa_r;

  assign phase = {angle, {(32-DW){1'b0}}};
  assign r     = phase[29:0];
  assign fold  = (r > 30'h2000_0000);

  always_ff @(posedge clk) begin
    if (en) begin
      arg_r      <= fold ? 30'(ONE_Q30 - {1'b0, r}) : r;
      fa_r.quad  <= quad_t'(phase[31:30]);
      fa_r.swap  <= fold;
    end
  end

  // Scale to radians, then square.
  logic [61:0] xprod;
  logic [29:0] x_r;
  fold_t       fb_r;
  logic [59:0] x2prod;
  logic [29:0] xc_r;
  logic [29:0] x2c_r;
  fold_t       fc_r;

  assign xprod  = arg_r * PI_Q30;
  assign x2prod = x_r * x_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= xprod[60:31];
      fb_r  <= fa_r;
      xc_r  <= x_r;
      x2c_r <= x2prod[59:30];
      fc_r  <= fb_r;
    end
  end

  // Horner steps: a product stage followed by a reciprocal divide stage.
  logic [29:0] ps_r  [NSTEP];
  logic [29:0] pc_r  [NSTEP];
  logic [29:0] xp_r  [NSTEP];
  logic [29:0] x2p_r [NSTEP];
  fold_t       fp_r  [NSTEP];
  logic [30:0] ts_r  [NSTEP];
  logic [30:0] tc_r  [NSTEP];
  logic [29:0] xt_r  [NSTEP];
  logic [29:0] x2t_r [NSTEP];
  fold_t       ft_r  [NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam int DS = SIN_DIV[i];
    localparam int DC = COS_DIV[i];
    localparam int KS = SIN_SH[i];
    localparam int KC = COS_SH[i];
    localparam logic [63:0] MS64 = ((64'd1 << KS) + 64'(DS) - 64'd1) / 64'(DS);
    localparam logic [63:0] MC64 = ((64'd1 << KC) + 64'(DC) - 64'd1) / 64'(DC);
    localparam logic [31:0] MS = MS64[31:0];
    localparam logic [31:0] MC = MC64[31:0];

    logic [29:0] x_in;
    logic [29:0] x2_in;
    logic [30:0] ts_in;
    logic [30:0] tc_in;
    fold_t       f_in;
    logic [60:0] pps;
    logic [60:0] ppc;
    logic [61:0] qs_full;
    logic [61:0] qc_full;
    logic [61:0] qs;
    logic [61:0] qc;

    if (i == 0) begin : g_first
      assign x_in  = xc_r;
      assign x2_in = x2c_r;
      assign ts_in = ONE_Q30;
      assign tc_in = ONE_Q30;
      assign f_in  = fc_r;
    end else begin : g_next
      assign x_in  = xt_r[i-1];
      assign x2_in = x2t_r[i-1];
      assign ts_in = ts_r[i-1];
      assign tc_in = tc_r[i-1];
      assign f_in  = ft_r[i-1];
    end

    assign pps     = x2_in * ts_in;
    assign ppc     = x2_in * tc_in;
    assign qs_full = ps_r[i] * MS;
    assign qc_full = pc_r[i] * MC;
    assign qs      = qs_full >> KS;
    assign qc      = qc_full >> KC;

    always_ff @(posedge clk) begin
      if (en) begin
        ps_r[i]  <= pps[59:30];
        pc_r[i]  <= ppc[59:30];
        xp_r[i]  <= x_in;
        x2p_r[i] <= x2_in;
        fp_r[i]  <= f_in;
        ts_r[i]  <= ONE_Q30 - {1'b0, qs[29:0]};
        tc_r[i]  <= ONE_Q30 - {1'b0, qc[29:0]};
        xt_r[i]  <= xp_r[i];
        x2t_r[i] <= x2p_r[i];
        ft_r[i]  <= fp_r[i];
      end
    end
  end

  // Finish the sine, undo the octant fold, then apply the quadrant.
  logic [60:0] sprod;
  logic [30:0] sv_r;
  logic [30:0] cv_r;
  quad_t       qf_r;
  logic signed [TW-1:0] sp;
  logic signed [TW-1:0] cp;
  trig_t       trig_r;
  trig_t       trig_nxt;

  assign sprod = xt_r[NSTEP-1] * ts_r[NSTEP-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r <= ft_r[NSTEP-1].swap ? tc_r[NSTEP-1] : sprod[60:30];
      cv_r <= ft_r[NSTEP-1].swap ? sprod[60:30] : tc_r[NSTEP-1];
      qf_r <= ft_r[NSTEP-1].quad;
    end
  end

  assign sp = {1'b0, sv_r};
  assign cp = {1'b0, cv_r};

  always_comb begin
    case (qf_r)
      QUAD_0: begin
        trig_nxt.s = sp;
        trig_nxt.c = cp;
      end
      QUAD_1: begin
        trig_nxt.s = cp;
        trig_nxt.c = -sp;
      end
      QUAD_2: begin
        trig_nxt.s = -sp;
        trig_nxt.c = -cp;
      end
      default: begin
        trig_nxt.s = -cp;
        trig_nxt.c = sp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

[rtl/ezr_merge.sv]
// Merging stage: combines the three lanes' sines and cosines into R = Rz*Ry*Rx.
// Depends on ezr_pkg.
module ezr_merge import ezr_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  trig_t tx,
  input  trig_t ty,
  input  trig_t tz,
  output mat_t  mat
);

  // Stage 1: sy*sx and sy*cx exact.
  logic signed [63:0] sysx_p_r;
  logic signed [63:0] sycx_p_r;
  trig_t t1x_r, t1y_r, t1z_r;
  // Stage 2: rounded to Q30.
  logic signed [TW-1:0] sysx_r;
  logic signed [TW-1:0] sycx_r;
  trig_t t2x_r, t2y_r, t2z_r;
  // Stage 3: two-factor products in Q60.
  logic signed [63:0] p_czcy_r, p_czsysx_r, p_szcx_r, p_czsycx_r, p_szsx_r;
  logic signed [63:0] p_szcy_r, p_szsysx_r, p_czcx_r, p_szsycx_r, p_czsx_r;
  logic signed [63:0] p_cysx_r, p_cycx_r, p_nsy_r;
  logic signed [63:0] sy64;
  // Stage 4: matrix entries in Q60.
  logic signed [63:0] e01_r, e02_r, e11_r, e12_r;
  logic signed [63:0] e00_r, e10_r, e20_r, e21_r, e22_r;
  mat_t mat_r;

  assign sy64 = t2y_r.s;

  always_ff @(posedge clk) begin
    if (en) begin
      sysx_p_r   <= ty.s * tx.s;
      sycx_p_r   <= ty.s * tx.c;
      t1x_r      <= tx;
      t1y_r      <= ty;
      t1z_r      <= tz;

      sysx_r     <= rnd_q30(sysx_p_r);
      sycx_r     <= rnd_q30(sycx_p_r);
      t2x_r      <= t1x_r;
      t2y_r      <= t1y_r;
      t2z_r      <= t1z_r;

      p_czcy_r   <= t2z_r.c * t2y_r.c;
      p_czsysx_r <= t2z_r.c * sysx_r;
      p_szcx_r   <= t2z_r.s * t2x_r.c;
      p_czsycx_r <= t2z_r.c * sycx_r;
      p_szsx_r   <= t2z_r.s * t2x_r.s;
      p_szcy_r   <= t2z_r.s * t2y_r.c;
      p_szsysx_r <= t2z_r.s * sysx_r;
      p_czcx_r   <= t2z_r.c * t2x_r.c;
      p_szsycx_r <= t2z_r.s * sycx_r;
      p_czsx_r   <= t2z_r.c * t2x_r.s;
      p_cysx_r   <= t2y_r.c * t2x_r.s;
      p_cycx_r   <= t2y_r.c * t2x_r.c;
      p_nsy_r    <= -(sy64 <<< 30);

      e00_r      <= p_czcy_r;
      e01_r      <= p_czsysx_r - p_szcx_r;
      e02_r      <= p_czsycx_r + p_szsx_r;
      e10_r      <= p_szcy_r;
      e11_r      <= p_szsysx_r + p_czcx_r;
      e12_r      <= p_szsycx_r - p_czsx_r;
      e20_r      <= p_nsy_r;
      e21_r      <= p_cysx_r;
      e22_r      <= p_cycx_r;

      mat_r.r00  <= out_code(e00_r);
      mat_r.r01  <= out_code(e01_r);
      mat_r.r02  <= out_code(e02_r);
      mat_r.r10  <= out_code(e10_r);
      mat_r.r11  <= out_code(e11_r);
      mat_r.r12  <= out_code(e12_r);
      mat_r.r20  <= out_code(e20_r);
      mat_r.r21  <= out_code(e21_r);
      mat_r.r22  <= out_code(e22_r);
    end
  end

  assign mat = mat_r;

endmodule
